[rtl/conv2d_same_zero_pad_macros.svh]
// assertion helpers
`ifndef CONV2D_SAME_ZERO_PAD_MACROS_SVH
`define CONV2D_SAME_ZERO_PAD_MACROS_SVH
`define C2D_ASSERT_IMPL(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define C2D_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[rtl/c2d_pkg.sv]
// ----------------------------------------------------------------------------
// c2d_pkg
// shared types and constants of the same-size convolution
// ----------------------------------------------------------------------------
package c2d_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MAX_KERNEL_DEF = 5;
   localparam int PIXEL_BITS     = 16;
   localparam int COEF_BITS      = 16;
   localparam int RESULT_BITS    = 36;
   localparam int CFG_BITS       = 11;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [1:0] FUNC_COEF   = 2'd0;
   localparam logic [1:0] FUNC_PIXEL  = 2'd1;
   localparam logic [1:0] FUNC_DRAIN  = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_KHEIGHT  = 2'd2;
   localparam logic [1:0] REG_KWIDTH   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_SUM,
      ST_SEND
   } back_state_type;
endpackage

[rtl/conv2d_same_zero_pad.sv]
// ----------------------------------------------------------------------------
// conv2d_same_zero_pad
// same-size 2d correlation with zero padding, streaming line buffers
// results come one at a time from the single shared multiplier; the back side
// takes no new beat while a window is gathered, summed or waiting to be sent
// reset is synchronous, clears counts and restores registers to 1024, 1024, 3, 3
// ----------------------------------------------------------------------------
`include "conv2d_same_zero_pad_macros.svh"
module conv2d_same_zero_pad #(
   parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [4:0]         req_coef_index,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [35:0] rsp_result_value,
   output logic [9:0]         rsp_out_row,
   output logic [9:0]         rsp_out_col,
   output logic               rsp_frame_last,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_write_data
);
   logic [10:0] w_ff, h_ff;
   logic [2:0]  kh_ff, kw_ff;
   logic abort, q_valid, q_take;
   logic [1:0] q_func;
   logic [4:0] q_index;
   logic signed [15:0] q_data;

   assign abort = csr_write_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= 11'd1024; h_ff <= 11'd1024; kh_ff <= 3'd3; kw_ff <= 3'd3;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            c2d_pkg::REG_WIDTH:   w_ff  <= csr_write_data;
            c2d_pkg::REG_HEIGHT:  h_ff  <= csr_write_data;
            c2d_pkg::REG_KHEIGHT: kh_ff <= csr_write_data[2:0];
            c2d_pkg::REG_KWIDTH:  kw_ff <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   c2d_front #(.NCOEF(MAX_KERNEL*MAX_KERNEL)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_coef_index, .req_sample,
      .q_valid, .q_func, .q_index, .q_data, .q_take
   );

   c2d_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_KERNEL(MAX_KERNEL))
   u_back (
      .clock, .reset, .w_cfg(w_ff), .h_cfg(h_ff), .kh_cfg(kh_ff), .kw_cfg(kw_ff),
      .abort, .q_valid, .q_func, .q_index, .q_data, .q_take,
      .rsp_valid, .rsp_stall, .rsp_result_value, .rsp_out_row, .rsp_out_col,
      .rsp_frame_last
   );

   `C2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall && !csr_write_enable, rsp_valid, "result beat dropped while stalled")
   `C2D_ASSERT_IMPL(a_take_q, clock, reset, q_take, q_valid, "queue read while empty")
endmodule

[rtl/c2d_front.sv]
// ----------------------------------------------------------------------------
// c2d_front
// accepts beats, drops ignored beats, queues the rest in order for the back
// ----------------------------------------------------------------------------
module c2d_front #(
   parameter int NCOEF      = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [4:0]                  req_coef_index,
   input  logic signed [15:0]          req_sample,
   output logic                        q_valid,
   output logic [1:0]                  q_func,
   output logic [4:0]                  q_index,
   output logic signed [15:0]          q_data,
   input  logic                        q_take
);
   localparam int QD = c2d_pkg::QUEUE_DEPTH;
   localparam int QA = $clog2(QD);
   localparam int QW = 2 + 5 + c2d_pkg::PIXEL_BITS;
   logic [QW-1:0] mem_ff [QD];
   logic [QW-1:0] rd_word;
   logic [QA-1:0] wp_ff, rp_ff;
   logic [QA:0]   cnt_ff, cnt_in;
   logic          acc, push, keep_coef;

   assign req_stall = (cnt_ff == (QA+1)'(QD));
   assign acc       = req_valid && !req_stall;
   // unused func code and out-of-range coefficient index are taken and dropped
   assign keep_coef = req_func == c2d_pkg::FUNC_COEF && 32'(req_coef_index) < NCOEF;
   assign push      = acc && (keep_coef || req_func == c2d_pkg::FUNC_PIXEL ||
                              req_func == c2d_pkg::FUNC_DRAIN);
   assign q_valid   = cnt_ff != '0;
   assign rd_word   = mem_ff[rp_ff];
   assign q_func    = rd_word[QW-1 -: 2];
   assign q_index   = rd_word[QW-3 -: 5];
   assign q_data    = rd_word[15:0];
   assign cnt_in    = cnt_ff + (QA+1)'(push) - (QA+1)'(q_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + QA'(1);
         if (q_take) rp_ff <= rp_ff + QA'(1);
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= {req_func, req_coef_index, req_sample};
   end
endmodule

[rtl/c2d_back.sv]
// ----------------------------------------------------------------------------
// c2d_back
// line buffers, window gather and multiply-accumulate, one pixel at a time
// ----------------------------------------------------------------------------
module c2d_back #(
   parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [10:0]                 w_cfg,
   input  logic [10:0]                 h_cfg,
   input  logic [2:0]                  kh_cfg,
   input  logic [2:0]                  kw_cfg,
   input  logic                        abort,
   input  logic                        q_valid,
   input  logic [1:0]                  q_func,
   input  logic [4:0]                  q_index,
   input  logic signed [15:0]          q_data,
   output logic                        q_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [35:0]          rsp_result_value,
   output logic [9:0]                  rsp_out_row,
   output logic [9:0]                  rsp_out_col,
   output logic                        rsp_frame_last
);
   localparam int WA  = $clog2(MAX_WIDTH);
   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int HB  = $clog2(MAX_HEIGHT + 1);
   localparam int KB  = $clog2(MAX_KERNEL + 1);
   localparam int RA  = $clog2(MAX_KERNEL) > 0 ? $clog2(MAX_KERNEL) : 1;
   localparam int NK  = MAX_KERNEL * MAX_KERNEL;
   localparam int NA  = $clog2(NK) > 0 ? $clog2(NK) : 1;
   localparam int PB  = 2 * c2d_pkg::PIXEL_BITS;

   logic signed [15:0] lb_mem [MAX_KERNEL][MAX_WIDTH];
   logic signed [15:0] kmem [NK];
   logic signed [15:0] rd_ff;
   logic signed [15:0] kd_ff;
   logic signed [15:0] pix_in;

   logic [WB-1:0] w;
   logic [HB-1:0] h;
   logic [KB-1:0] kh, kw, ph, pw;
   always_comb begin
      w  = (w_cfg == '0) ? WB'(1) : (32'(w_cfg) > MAX_WIDTH ? WB'(MAX_WIDTH) : WB'(w_cfg));
      h  = (h_cfg == '0) ? HB'(1) : (32'(h_cfg) > MAX_HEIGHT ? HB'(MAX_HEIGHT) : HB'(h_cfg));
      kh = (kh_cfg == '0) ? KB'(1) : (32'(kh_cfg) > MAX_KERNEL ? KB'(MAX_KERNEL) : KB'(kh_cfg));
      kw = (kw_cfg == '0) ? KB'(1) : (32'(kw_cfg) > MAX_KERNEL ? KB'(MAX_KERNEL) : KB'(kw_cfg));
      ph = kh >> 1;
      pw = kw >> 1;
   end

   // input position (row, col, line slot) and output position
   logic [HB:0]   in_row_ff;
   logic [WB-1:0] in_col_ff;
   logic [RA-1:0] in_slot_ff;
   logic [HB:0]   out_row_ff;
   logic [WB-1:0] out_col_ff;
   logic [RA-1:0] out_slot_ff;
   logic          out_on_ff;
   logic [HB+WB+1:0] lagc_ff;
   logic [HB+WB+1:0] lag;

   c2d_pkg::back_state_type st_ff, st_in;
   logic [KB-1:0] m_ff, n_ff;
   logic [NA-1:0] ki_ff;
   logic          mv_ff;
   logic signed [PB-1:0]  prod_ff;
   logic                  pv_ff;
   logic signed [35:0]    acc_ff;
   logic                  gdone_ff;
   logic                  take, counts;

   always_comb lag = (HB+WB+2)'(kh - KB'(1) - ph) * (HB+WB+2)'(w) + (HB+WB+2)'(kw - KB'(1) - pw);

   // window tap: row r = out_row+m-ph, col c = out_col+n-pw
   logic signed [HB+2:0] r_s;
   logic signed [WB+1:0] c_s;
   logic          inb;
   logic [RA-1:0] slot;
   logic [KB:0]   slot_sum;
   always_comb begin
      r_s = $signed({2'b00, out_row_ff}) + $signed((HB+3)'(m_ff)) - $signed((HB+3)'(ph));
      c_s = $signed({2'b00, out_col_ff}) + $signed((WB+2)'(n_ff)) - $signed((WB+2)'(pw));
      inb = (r_s >= 0) && (r_s < $signed((HB+3)'(h))) && (c_s >= 0) && (c_s < $signed((WB+2)'(w)));
      slot_sum = (KB+1)'(out_slot_ff) + (KB+1)'(m_ff) + (KB+1)'(MAX_KERNEL) - (KB+1)'(ph);
      if (slot_sum >= (KB+1)'(2*MAX_KERNEL)) slot = RA'(slot_sum - (KB+1)'(2*MAX_KERNEL));
      else if (slot_sum >= (KB+1)'(MAX_KERNEL)) slot = RA'(slot_sum - (KB+1)'(MAX_KERNEL));
      else slot = RA'(slot_sum);
   end

   assign take   = (st_ff == c2d_pkg::ST_IDLE) && q_valid && !abort;
   assign q_take = take;
   // drains outside a frame are dropped, coefficient beats only fill the store
   assign counts = take && (q_func == c2d_pkg::FUNC_PIXEL ||
                            (q_func == c2d_pkg::FUNC_DRAIN &&
                             (in_row_ff != '0 || in_col_ff != '0)));
   assign pix_in = (q_func == c2d_pkg::FUNC_PIXEL) ? q_data : '0;

   logic lastpix;
   assign lastpix = out_row_ff == (HB+1)'(h - HB'(1)) && out_col_ff == w - WB'(1);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         c2d_pkg::ST_IDLE:   if (counts) st_in = (out_on_ff || lagc_ff == lag) ?
                                              c2d_pkg::ST_GATHER : c2d_pkg::ST_IDLE;
         c2d_pkg::ST_GATHER: if (gdone_ff && !mv_ff && !pv_ff) st_in = c2d_pkg::ST_SEND;
         c2d_pkg::ST_SUM:    st_in = c2d_pkg::ST_SEND;
         c2d_pkg::ST_SEND:   if (!rsp_stall) st_in = c2d_pkg::ST_IDLE;
         default:            st_in = c2d_pkg::ST_IDLE;
      endcase
      if (abort) st_in = c2d_pkg::ST_IDLE;
   end

   assign rsp_valid        = st_ff == c2d_pkg::ST_SEND;
   assign rsp_result_value = acc_ff;
   assign rsp_out_row      = 10'(out_row_ff);
   assign rsp_out_col      = 10'(out_col_ff);
   assign rsp_frame_last   = lastpix;

   logic gstep_last;
   assign gstep_last = (n_ff == kw - KB'(1)) && (m_ff == kh - KB'(1));

   always_ff @(posedge clock) begin
      if (take && q_func == c2d_pkg::FUNC_COEF) kmem[NA'(q_index)] <= q_data;
      if (counts && in_row_ff < (HB+1)'(h)) lb_mem[in_slot_ff][in_col_ff[WA-1:0]] <= pix_in;
      if (st_ff == c2d_pkg::ST_GATHER && !gdone_ff) begin
         rd_ff <= lb_mem[slot][c_s[WA-1:0]];
         kd_ff <= kmem[ki_ff];
      end
      prod_ff <= rd_ff * kd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || abort) begin
         st_ff <= c2d_pkg::ST_IDLE;
         in_row_ff <= '0; in_col_ff <= '0; in_slot_ff <= '0;
         out_row_ff <= '0; out_col_ff <= '0; out_slot_ff <= '0;
         out_on_ff <= 1'b0; lagc_ff <= '0;
         m_ff <= '0; n_ff <= '0; ki_ff <= '0; mv_ff <= 1'b0; pv_ff <= 1'b0;
         acc_ff <= '0; gdone_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         mv_ff <= (st_ff == c2d_pkg::ST_GATHER) && !gdone_ff && inb;
         pv_ff <= mv_ff;
         if (counts) begin
            if (in_col_ff == w - WB'(1)) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + (HB+1)'(1);
               in_slot_ff <= (in_slot_ff == RA'(MAX_KERNEL-1)) ? '0 : in_slot_ff + RA'(1);
            end else in_col_ff <= in_col_ff + WB'(1);
            if (!out_on_ff) begin
               if (lagc_ff == lag) out_on_ff <= 1'b1;
               else lagc_ff <= lagc_ff + (HB+WB+2)'(1);
            end
            m_ff <= '0; n_ff <= '0; ki_ff <= '0; acc_ff <= '0; gdone_ff <= 1'b0;
         end else if (pv_ff) acc_ff <= acc_ff + 36'(prod_ff);
         if (st_ff == c2d_pkg::ST_GATHER && !gdone_ff) begin
            if (gstep_last) gdone_ff <= 1'b1;
            else if (n_ff == kw - KB'(1)) begin
               n_ff <= '0; m_ff <= m_ff + KB'(1);
            end else n_ff <= n_ff + KB'(1);
            ki_ff <= ki_ff + NA'(1);
         end
         if (st_ff == c2d_pkg::ST_SEND && !rsp_stall) begin
            if (lastpix) begin
               in_row_ff <= '0; in_col_ff <= '0; in_slot_ff <= '0;
               out_row_ff <= '0; out_col_ff <= '0; out_slot_ff <= '0;
               out_on_ff <= 1'b0; lagc_ff <= '0;
            end else if (out_col_ff == w - WB'(1)) begin
               out_col_ff <= '0;
               out_row_ff <= out_row_ff + (HB+1)'(1);
               out_slot_ff <= (out_slot_ff == RA'(MAX_KERNEL-1)) ? '0 : out_slot_ff + RA'(1);
            end else out_col_ff <= out_col_ff + WB'(1);
         end
      end
   end
endmodule

[bench/tb_conv2d_same_zero_pad.sv]
// ----------------------------------------------------------------------------
// tb_conv2d_same_zero_pad
// self-checking bench for the streaming same-size convolution: a directed
// table of single-pixel frames, then random frames of fixed and random geometry. Each
// output beat is checked field by field against a behavioral line-buffer
// predictor.
// ----------------------------------------------------------------------------
module tb_conv2d_same_zero_pad;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KMAX = 5;
   localparam int WMAX = 1024;
   localparam int HMAX = 1024;
   localparam int WATCHDOG = 4000;
   localparam int SETTLE = 40;

   typedef struct {
      logic signed [35:0] value;
      logic [9:0]         row;
      logic [9:0]         col;
      logic               last;
   } pixel_out_type;

   typedef struct {
      logic [1:0]         func;
      logic [4:0]         idx;
      logic signed [15:0] sample;
      bit                 typed;
      longint             value;
   } table_row_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_func = c2d_pkg::FUNC_PIXEL;
   logic [4:0]         req_coef_index = 0;
   logic signed [15:0] req_sample = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [35:0] rsp_result_value;
   logic [9:0]         rsp_out_row;
   logic [9:0]         rsp_out_col;
   logic               rsp_frame_last;
   logic               csr_write_enable = 0;
   logic [1:0]         csr_index = c2d_pkg::REG_WIDTH;
   logic [10:0]        csr_write_data = 0;

   conv2d_same_zero_pad dut (.*);

   always #4 clock = ~clock;

   // predictor state
   longint     coef_mem [KMAX*KMAX];
   longint     line_mem [KMAX*WMAX];
   int         pix_count;
   int         img_w, img_h, ker_h, ker_w;
   bit         frame_done;
   pixel_out_type pending_pixels [$];

   int  errors = 0;
   int  beats_in = 0;
   int  beats_out = 0;
   int  frames_seen = 0;
   int  idle_cycles = 0;
   bit  quiet = 0;
   int  rsp_burst = 0;

   function automatic int clamp_reg(int v, int hi);
      if (v < 1) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // one accepted beat through the line-buffer window sum
   task automatic predict_beat(input logic [1:0] func, input logic [4:0] idx,
                               input logic signed [15:0] sample,
                               output bit has_out, output pixel_out_type res);
      int w, h, kh, kw, ph, pw, lag, p, q, oi, oj, r, c;
      longint sum, v;
      has_out = 0;
      res = '{default: 0};
      if (func == c2d_pkg::FUNC_COEF) begin
         if (idx < KMAX*KMAX) coef_mem[idx] = sample;
         return;
      end
      if (func != c2d_pkg::FUNC_PIXEL && func != c2d_pkg::FUNC_DRAIN) return;
      if (func == c2d_pkg::FUNC_DRAIN && pix_count == 0) return;
      w = clamp_reg(img_w, WMAX);
      h = clamp_reg(img_h, HMAX);
      kh = clamp_reg(ker_h, KMAX);
      kw = clamp_reg(ker_w, KMAX);
      ph = kh / 2;
      pw = kw / 2;
      lag = (kh - 1 - ph) * w + (kw - 1 - pw);
      p = pix_count;
      if (p / w < h)
         line_mem[((p / w) % KMAX) * WMAX + (p % w)] =
            (func == c2d_pkg::FUNC_PIXEL) ? sample : 0;
      pix_count = p + 1;
      if (p < lag) return;
      q = p - lag;
      oi = q / w;
      oj = q % w;
      sum = 0;
      for (int m = 0; m < kh; m++) begin
         for (int n = 0; n < kw; n++) begin
            r = oi + m - ph;
            c = oj + n - pw;
            v = 0;
            if (r >= 0 && r < h && c >= 0 && c < w) v = line_mem[(r % KMAX) * WMAX + c];
            sum += v * coef_mem[m * kw + n];
         end
      end
      has_out = 1;
      res.value = sum[35:0];
      res.row = oi[9:0];
      res.col = oj[9:0];
      res.last = (q == w * h - 1);
      if (res.last) begin
         pix_count = 0;
         frame_done = 1;
      end
   endtask

   // sender: optional gap burst, then hold the beat until taken
   task automatic send_beat(input logic [1:0] func, input logic [4:0] idx,
                            input logic signed [15:0] sample,
                            input bit typed = 0, input longint typed_value = 0);
      bit has_out;
      pixel_out_type res;
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 99) < 15) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_func <= func;
      req_coef_index <= idx;
      req_sample <= sample;
      do @(posedge clock); while (req_stall);
      predict_beat(func, idx, sample, has_out, res);
      if (has_out) begin
         if (typed) res.value = typed_value[35:0];
         pending_pixels.push_back(res);
      end
      beats_in++;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data[10:0];
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         c2d_pkg::REG_WIDTH:   img_w = data & 'h7ff;
         c2d_pkg::REG_HEIGHT:  img_h = data & 'h7ff;
         c2d_pkg::REG_KHEIGHT: ker_h = data & 'h7;
         default:              ker_w = data & 'h7;
      endcase
      pix_count = 0;
   endtask

   task automatic set_geometry(input int w, input int h, input int kh, input int kw);
      wait_drained();
      write_reg(c2d_pkg::REG_WIDTH, w);
      write_reg(c2d_pkg::REG_HEIGHT, h);
      write_reg(c2d_pkg::REG_KHEIGHT, kh);
      write_reg(c2d_pkg::REG_KWIDTH, kw);
   endtask

   function automatic logic signed [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 0;
         default: return 16'($urandom());
      endcase
   endfunction

   // random frames; with cut set the last frame may stop early
   task automatic run_frames(input int count, input bit cut);
      int r, stop_at, sent;
      for (int f = 0; f < count; f++) begin
         for (int k = 0; k < KMAX*KMAX; k++)
            send_beat(c2d_pkg::FUNC_COEF, k[4:0], rand_sample());
         frame_done = 0;
         sent = 0;
         stop_at = (cut && f == count - 1) ? $urandom_range(1, 20) : -1;
         while (!frame_done && sent != stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 82) send_beat(c2d_pkg::FUNC_PIXEL, 5'($urandom()), rand_sample());
            else if (r < 90)
               send_beat(c2d_pkg::FUNC_DRAIN, 5'($urandom()), 16'($urandom()));
            else if (r < 94)
               send_beat(c2d_pkg::FUNC_COEF, 5'($urandom_range(0, 24)), rand_sample());
            else if (r < 97)
               send_beat(c2d_pkg::FUNC_COEF, 5'($urandom_range(25, 31)), 16'($urandom()));
            else send_beat(c2d_pkg::FUNC_UNUSED, 5'($urandom()), 16'($urandom()));
            sent++;
         end
      end
   endtask

   // result stall bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 0;
         rsp_burst <= 0;
      end else if (rsp_burst > 0) begin
         rsp_burst <= rsp_burst - 1;
      end else if ($urandom_range(0, 99) < 12) begin
         rsp_stall <= 1;
         rsp_burst <= $urandom_range(0, 9);
      end else begin
         rsp_stall <= 0;
      end
   end

   // output checker
   always @(posedge clock) begin
      pixel_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (rsp_frame_last) frames_seen++;
         if (pending_pixels.size() == 0) begin
            $display("%0t unexpected beat: actual value %0d row %0d col %0d last %0b",
                     $time, rsp_result_value, rsp_out_row, rsp_out_col, rsp_frame_last);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_result_value !== want.value || rsp_out_row !== want.row ||
                rsp_out_col !== want.col || rsp_frame_last !== want.last) begin
               $display("%0t mismatch: expected %0d r%0d c%0d l%0b actual %0d r%0d c%0d l%0b",
                        $time, want.value, want.row, want.col, want.last,
                        rsp_result_value, rsp_out_row, rsp_out_col, rsp_frame_last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb_conv2d_same_zero_pad NOT OK");
         $finish;
      end
   end

   table_row_type directed [16] = '{
      '{c2d_pkg::FUNC_COEF,    0, 16'sh4000, 0, 0},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh7fff, 1, 64'sd536854528},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh8000, 1, -64'sd536870912},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh0000, 1, 0},
      '{c2d_pkg::FUNC_UNUSED,  0, 16'sh1234, 0, 0},
      '{c2d_pkg::FUNC_DRAIN,   0, 16'sh0000, 0, 0},
      '{c2d_pkg::FUNC_COEF,   31, 16'sh0000, 0, 0},
      '{c2d_pkg::FUNC_COEF,   25, 16'sh0000, 0, 0},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh0001, 1, 16384},
      '{c2d_pkg::FUNC_COEF,    0, 16'sh8000, 0, 0},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh7fff, 1, -64'sd1073709056},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh8000, 1, 64'sd1073741824},
      '{c2d_pkg::FUNC_COEF,    0, 16'sh7fff, 0, 0},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh8000, 1, -64'sd1073709056},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'sh5555, 0, 0},
      '{c2d_pkg::FUNC_PIXEL,   0, 16'shaaaa, 0, 0}
   };

   initial begin
      int phases;
      for (int k = 0; k < KMAX*KMAX; k++) coef_mem[k] = 0;
      for (int k = 0; k < KMAX*WMAX; k++) line_mem[k] = 0;
      pix_count = 0;
      img_w = 1024;
      img_h = 1024;
      ker_h = 3;
      ker_w = 3;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_geometry(1, 1, 1, 1);
      foreach (directed[i])
         send_beat(directed[i].func, directed[i].idx, directed[i].sample,
                   directed[i].typed, directed[i].value);

      // fixed geometries, extremes and out-of-range register values included
      set_geometry(5, 4, 3, 3);  run_frames(1, 0);
      set_geometry(7, 3, 5, 5);  run_frames(1, 1);
      set_geometry(4, 6, 2, 4);  run_frames(1, 0);
      set_geometry(3, 3, 5, 1);  run_frames(1, 0);
      set_geometry(2047, 1, 3, 3); run_frames(1, 1);
      set_geometry(1, 2047, 5, 5); run_frames(1, 1);
      set_geometry(0, 1, 0, 7);  run_frames(2, 0);
      phases = 8;

      while (beats_in < 360) begin
         set_geometry($urandom_range(1, 8), $urandom_range(1, 6),
                      $urandom_range(0, 7), $urandom_range(0, 7));
         run_frames($urandom_range(1, 2), $urandom_range(0, 3) == 0);
         phases++;
      end

      wait_drained();
      quiet = 1;
      set_geometry(6, 5, 3, 3);
      run_frames(1, 0);
      phases++;
      wait_drained();

      $display("%0d phases of frame geometry, %0d input beats, %0d output beats, %0d frames",
               phases, beats_in, beats_out, frames_seen);
      $display("kernels 1x1 to 5x5, register values past their limits, drains and skips");
      if (errors == 0 && pending_pixels.size() == 0) begin
         $display("tb_conv2d_same_zero_pad OK");
      end else begin
         $display("tb_conv2d_same_zero_pad NOT OK");
      end
      $finish;
   end
endmodule

[files.f]
+incdir+rtl
rtl/c2d_pkg.sv
rtl/c2d_front.sv
rtl/c2d_back.sv
rtl/conv2d_same_zero_pad.sv
bench/tb_conv2d_same_zero_pad.sv
